@@ rtl/tdb_pkg.sv @@
// Shared types, codes and helper functions for the 2D blitter engine.
// Depends on nothing; imported by tdb_ctrl, tdb_datapath and the top level.
package tdb_pkg;

  localparam int CW = 13;  // coordinate width: 12-bit field plus carry

  typedef enum logic [2:0] {
    OP_CLEAR      = 3'd0,
    OP_FILL       = 3'd1,
    OP_XOR        = 3'd2,
    OP_BLIT_BEGIN = 3'd3,
    OP_BLIT_PIX   = 3'd4,
    OP_COPY       = 3'd5,
    OP_READ       = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    CFG_SCREEN_W = 2'd0,
    CFG_SCREEN_H = 2'd1,
    CFG_FORMAT   = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    WS_ZERO  = 2'd0,
    WS_COLOR = 2'd1,
    WS_XOR   = 2'd2,
    WS_RDATA = 2'd3
  } wsel_t;

  typedef struct packed {
    logic  rd_en;
    logic  wr_en;
    wsel_t wsel;
  } dp_cmd_t;

  localparam logic [7:0] SCREEN_W_RST = 8'd128;
  localparam logic [7:0] SCREEN_H_RST = 8'd128;
  localparam logic       FORMAT_RST   = 1'b1;

  function automatic logic [31:0] to_native(input logic [31:0] c, input logic fmt);
    logic [31:0] n;
    n = {16'd0, c[23:19], c[15:10], c[7:3]};
    return fmt ? c : n;
  endfunction

  // Clip a length so that start + len stays within limit, stopping at zero.
  function automatic logic [CW-1:0] clip_len(input logic [CW-1:0] len,
                                             input logic [CW-1:0] start,
                                             input logic [CW-1:0] limit);
    logic [CW:0] sum;
    logic [CW-1:0] res;
    sum = {1'b0, start} + {1'b0, len};
    res = len;
    if (sum > {1'b0, limit}) begin
      res = (start >= limit) ? '0 : limit - start;
    end
    return res;
  endfunction

endpackage

@@ rtl/tdb_datapath.sv @@
// Frame store and write-data selection of the 2D blitter engine.
// Depends on tdb_pkg; driven by tdb_ctrl through a dp_cmd_t command.
module tdb_datapath #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128,
  parameter int AW         = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
  input  logic             clk,
  input  tdb_pkg::dp_cmd_t cmd,
  input  logic [AW-1:0]    rd_addr,
  input  logic [AW-1:0]    wr_addr,
  input  logic [31:0]      color,
  output logic [31:0]      rdata
);
  import tdb_pkg::*;

  localparam int STORE = MAX_WIDTH * MAX_HEIGHT;

  logic [31:0] mem [STORE];
  logic [31:0] rdata_r;
  logic [31:0] wdata;

  always_comb begin
    case (cmd.wsel)
      WS_ZERO:  wdata = '0;
      WS_COLOR: wdata = color;
      WS_XOR:   wdata = rdata_r ^ color;
      WS_RDATA: wdata = rdata_r;
      default:  wdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/tdb_ctrl.sv @@
// Command sequencer of the 2D blitter engine: clipping, pixel walk, blit state.
// Depends on tdb_pkg; steers tdb_datapath with a dp_cmd_t command.
module tdb_ctrl #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128,
  parameter int AW         = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [2:0]       in_command,
  input  logic [11:0]      in_dest_x,
  input  logic [11:0]      in_dest_y,
  input  logic [11:0]      in_src_x,
  input  logic [11:0]      in_src_y,
  input  logic [11:0]      in_rect_width,
  input  logic [11:0]      in_rect_height,
  input  logic [31:0]      in_color,
  input  logic [31:0]      in_key_color,
  output logic             out_valid,
  output logic [31:0]      out_read_data,
  output logic             out_status,
  output logic             out_blit_last,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [7:0]       cfg_data,
  output tdb_pkg::dp_cmd_t dp_cmd,
  output logic [AW-1:0]    dp_rd_addr,
  output logic [AW-1:0]    dp_wr_addr,
  output logic [31:0]      dp_color,
  input  logic [31:0]      dp_rdata
);
  import tdb_pkg::*;

  localparam int STORE = MAX_WIDTH * MAX_HEIGHT;
  localparam int PW    = 2 * CW;
  localparam logic [CW-1:0] MAXW_C = CW'(MAX_WIDTH);
  localparam logic [CW-1:0] MAXH_C = CW'(MAX_HEIGHT);
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SETUP, S_FILL, S_RMW_RD, S_RMW_WR, S_CLEAR, S_READ, S_READ_WAIT
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0]  op_r, op_nxt;
  logic [11:0] dx_r, dx_nxt, dy_r, dy_nxt, sx_r, sx_nxt, sy_r, sy_nxt;
  logic [11:0] rw_r, rw_nxt, rh_r, rh_nxt;
  logic [31:0] color_r, color_nxt, key_r, key_nxt;
  logic [11:0] bsx_r, bsx_nxt, bsy_r, bsy_nxt, bdx_r, bdx_nxt, bdy_r, bdy_nxt;
  logic [CW-1:0] lw_r, lw_nxt, lh_r, lh_nxt, i_r, i_nxt, j_r, j_nxt;
  logic        back_r, back_nxt;
  logic [AW-1:0] waddr_r, waddr_nxt, clr_r, clr_nxt;
  logic [7:0]  sw_r, sw_nxt, sh_r, sh_nxt;
  logic        fmt_r, fmt_nxt;
  logic [11:0] bo_x_r, bo_x_nxt, bo_y_r, bo_y_nxt, bs_w_r, bs_w_nxt, bs_h_r, bs_h_nxt;
  logic [11:0] bcol_r, bcol_nxt, brow_r, brow_nxt;
  logic [31:0] bkey_r, bkey_nxt;
  logic        bact_r, bact_nxt;
  logic        ov_r, ov_nxt, ost_r, ost_nxt, olast_r, olast_nxt;
  logic [31:0] ord_r, ord_nxt;

  logic [CW-1:0] vw, vh, dx13, dy13, sx13, sy13, rw13, rh13;
  logic [CW-1:0] rr, cc, srow, scol, drow, dcol;
  logic [PW-1:0] sidx, didx, bidx;
  logic [CW-1:0] rx_end, ry_end, rect_w, rect_h, cw, ch;
  logic          rect_on, backward, last_px;
  logic [CW-1:0] px, py;
  logic [11:0]   bcol_inc, brow_inc;
  logic [31:0]   nat;

  assign vw = ({5'd0, sw_r} < MAXW_C) ? {5'd0, sw_r} : MAXW_C;
  assign vh = ({5'd0, sh_r} < MAXH_C) ? {5'd0, sh_r} : MAXH_C;
  assign dx13 = {1'b0, dx_r};
  assign dy13 = {1'b0, dy_r};
  assign sx13 = {1'b0, sx_r};
  assign sy13 = {1'b0, sy_r};
  assign rw13 = {1'b0, rw_r};
  assign rh13 = {1'b0, rh_r};

  // Walk order: backward when the destination sits after the source.
  assign rr   = back_r ? lh_r - 1'b1 - i_r : i_r;
  assign cc   = back_r ? lw_r - 1'b1 - j_r : j_r;
  assign srow = {1'b0, bsy_r} + rr;
  assign scol = {1'b0, bsx_r} + cc;
  assign drow = {1'b0, bdy_r} + rr;
  assign dcol = {1'b0, bdx_r} + cc;
  assign sidx = PW'(srow) * PW'(vw) + PW'(scol);
  assign didx = PW'(drow) * PW'(vw) + PW'(dcol);

  assign rx_end  = dx13 + rw13;
  assign ry_end  = dy13 + rh13;
  assign rect_on = (dx13 < vw) && (dy13 < vh);
  assign rect_w  = ((rx_end > vw) ? vw : rx_end) - dx13;
  assign rect_h  = ((ry_end > vh) ? vh : ry_end) - dy13;
  assign cw      = clip_len(clip_len(rw13, sx13, vw), dx13, vw);
  assign ch      = clip_len(clip_len(rh13, sy13, vh), dy13, vh);
  assign backward = (dy_r > sy_r) || ((dy_r == sy_r) && (dx_r > sx_r));
  assign last_px  = (j_r == lw_r - 1'b1) && (i_r == lh_r - 1'b1);

  assign px       = {1'b0, bo_x_r} + {1'b0, bcol_r};
  assign py       = {1'b0, bo_y_r} + {1'b0, brow_r};
  assign bidx     = PW'(py) * PW'(vw) + PW'(px);
  assign bcol_inc = bcol_r + 12'd1;
  assign brow_inc = brow_r + 12'd1;
  assign nat      = to_native(color_r, fmt_r);

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    dx_nxt = dx_r; dy_nxt = dy_r; sx_nxt = sx_r; sy_nxt = sy_r;
    rw_nxt = rw_r; rh_nxt = rh_r; color_nxt = color_r; key_nxt = key_r;
    bsx_nxt = bsx_r; bsy_nxt = bsy_r; bdx_nxt = bdx_r; bdy_nxt = bdy_r;
    lw_nxt = lw_r; lh_nxt = lh_r; i_nxt = i_r; j_nxt = j_r; back_nxt = back_r;
    waddr_nxt = waddr_r; clr_nxt = clr_r;
    sw_nxt = sw_r; sh_nxt = sh_r; fmt_nxt = fmt_r;
    bo_x_nxt = bo_x_r; bo_y_nxt = bo_y_r; bs_w_nxt = bs_w_r; bs_h_nxt = bs_h_r;
    bcol_nxt = bcol_r; brow_nxt = brow_r; bkey_nxt = bkey_r; bact_nxt = bact_r;
    ov_nxt = 1'b0; ost_nxt = ost_r; olast_nxt = olast_r; ord_nxt = ord_r;
    dp_cmd = '{rd_en: 1'b0, wr_en: 1'b0, wsel: WS_ZERO};
    dp_rd_addr = sidx[AW-1:0];
    dp_wr_addr = didx[AW-1:0];

    if (cfg_valid) begin
      case (cfg_index)
        CFG_SCREEN_W: sw_nxt = cfg_data;
        CFG_SCREEN_H: sh_nxt = cfg_data;
        CFG_FORMAT:   fmt_nxt = cfg_data[0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt = in_command;
          dx_nxt = in_dest_x; dy_nxt = in_dest_y;
          sx_nxt = in_src_x;  sy_nxt = in_src_y;
          rw_nxt = in_rect_width; rh_nxt = in_rect_height;
          color_nxt = in_color; key_nxt = in_key_color;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        // Default: finish now with a plain done beat.
        state_nxt = S_IDLE;
        ov_nxt = 1'b1; ost_nxt = 1'b0; olast_nxt = 1'b0; ord_nxt = '0;
        i_nxt = '0; j_nxt = '0; back_nxt = 1'b0;
        case (op_r)
          OP_CLEAR: begin
            ov_nxt = 1'b0; clr_nxt = '0; state_nxt = S_CLEAR;
          end
          OP_FILL, OP_XOR: begin
            if (rect_on && rect_w != '0 && rect_h != '0) begin
              ov_nxt = 1'b0;
              bsx_nxt = dx_r; bsy_nxt = dy_r; bdx_nxt = dx_r; bdy_nxt = dy_r;
              lw_nxt = rect_w; lh_nxt = rect_h;
              state_nxt = (op_r == OP_FILL) ? S_FILL : S_RMW_RD;
            end
          end
          OP_BLIT_BEGIN: begin
            bo_x_nxt = dx_r; bo_y_nxt = dy_r; bs_w_nxt = rw_r; bs_h_nxt = rh_r;
            bkey_nxt = key_r; bcol_nxt = '0; brow_nxt = '0;
            bact_nxt = (rw_r != '0) && (rh_r != '0);
          end
          OP_BLIT_PIX: begin
            if (!bact_r) begin
              ost_nxt = 1'b1;
            end else begin
              dp_wr_addr = bidx[AW-1:0];
              dp_cmd.wsel = WS_COLOR;
              dp_cmd.wr_en = (px < vw) && (py < vh) && (color_r != bkey_r);
              bcol_nxt = bcol_inc;
              if (bcol_inc >= bs_w_r) begin
                bcol_nxt = '0;
                brow_nxt = brow_inc;
                if (brow_inc >= bs_h_r) begin
                  brow_nxt = '0; bact_nxt = 1'b0; olast_nxt = 1'b1;
                end
              end
            end
          end
          OP_COPY: begin
            if (rw_r != '0 && rh_r != '0 && cw != '0 && ch != '0) begin
              ov_nxt = 1'b0;
              bsx_nxt = sx_r; bsy_nxt = sy_r; bdx_nxt = dx_r; bdy_nxt = dy_r;
              lw_nxt = cw; lh_nxt = ch; back_nxt = backward;
              state_nxt = S_RMW_RD;
            end
          end
          OP_READ: begin
            if (rect_on) begin
              ov_nxt = 1'b0;
              bsx_nxt = dx_r; bsy_nxt = dy_r;
              state_nxt = S_READ;
            end
          end
          default: ost_nxt = 1'b1;
        endcase
      end
      S_FILL, S_RMW_WR: begin
        dp_cmd.wr_en = 1'b1;
        if (state_r == S_FILL) begin
          dp_cmd.wsel = WS_COLOR;
        end else begin
          dp_wr_addr = waddr_r;
          dp_cmd.wsel = (op_r == OP_XOR) ? WS_XOR : WS_RDATA;
          state_nxt = S_RMW_RD;
        end
        // Advance the pixel walk; drop to idle after the last pixel.
        if (j_r == lw_r - 1'b1) begin
          j_nxt = '0;
          i_nxt = i_r + 1'b1;
        end else begin
          j_nxt = j_r + 1'b1;
        end
        if (last_px) begin
          state_nxt = S_IDLE;
          ov_nxt = 1'b1; ost_nxt = 1'b0; olast_nxt = 1'b0; ord_nxt = '0;
        end
      end
      S_RMW_RD: begin
        dp_cmd.rd_en = 1'b1;
        waddr_nxt = didx[AW-1:0];
        state_nxt = S_RMW_WR;
      end
      S_CLEAR: begin
        dp_cmd.wr_en = 1'b1;
        dp_cmd.wsel = WS_ZERO;
        dp_wr_addr = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
          ov_nxt = 1'b1; ost_nxt = 1'b0; olast_nxt = 1'b0; ord_nxt = '0;
        end
      end
      S_READ: begin
        dp_cmd.rd_en = 1'b1;
        state_nxt = S_READ_WAIT;
      end
      S_READ_WAIT: begin
        state_nxt = S_IDLE;
        ov_nxt = 1'b1; ost_nxt = 1'b0; olast_nxt = 1'b0; ord_nxt = dp_rdata;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sw_r <= SCREEN_W_RST; sh_r <= SCREEN_H_RST; fmt_r <= FORMAT_RST;
      bo_x_r <= '0; bo_y_r <= '0; bs_w_r <= '0; bs_h_r <= '0;
      bcol_r <= '0; brow_r <= '0; bkey_r <= '0; bact_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sw_r <= sw_nxt; sh_r <= sh_nxt; fmt_r <= fmt_nxt;
      bo_x_r <= bo_x_nxt; bo_y_r <= bo_y_nxt; bs_w_r <= bs_w_nxt; bs_h_r <= bs_h_nxt;
      bcol_r <= bcol_nxt; brow_r <= brow_nxt; bkey_r <= bkey_nxt; bact_r <= bact_nxt;
      ov_r <= ov_nxt;
    end
    op_r <= op_nxt;
    dx_r <= dx_nxt; dy_r <= dy_nxt; sx_r <= sx_nxt; sy_r <= sy_nxt;
    rw_r <= rw_nxt; rh_r <= rh_nxt; color_r <= color_nxt; key_r <= key_nxt;
    bsx_r <= bsx_nxt; bsy_r <= bsy_nxt; bdx_r <= bdx_nxt; bdy_r <= bdy_nxt;
    lw_r <= lw_nxt; lh_r <= lh_nxt; i_r <= i_nxt; j_r <= j_nxt; back_r <= back_nxt;
    waddr_r <= waddr_nxt; clr_r <= clr_nxt;
    ost_r <= ost_nxt; olast_r <= olast_nxt; ord_r <= ord_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_valid     = ov_r;
  assign out_read_data = ord_r;
  assign out_status    = ost_r;
  assign out_blit_last = olast_r;
  assign dp_color      = nat;

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (state_r == S_IDLE)) else $error("result beat outside idle");
  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == S_SETUP)) else $error("accepted beat not taken");
  a_blit_span_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    bact_r |-> (bs_w_r != '0 && bs_h_r != '0)) else $error("active blit with empty span");
  a_last_ends_blit: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && olast_r) |-> !bact_r) else $error("blit still active after last pixel");

endmodule

@@ rtl/two_d_blitter_engine.sv @@
// 2D blitter engine: clear, fill, xor fill, keyed blit, copy and readback.
// Each accepted command ends in a result beat. Read off screen, blit begin and blit
// pixel end in setup; fill writes each clipped pixel, xor fill and copy read then
// write each one, and clear zeroes the store, one store word a cycle. One item at
// a time. Reset (rst_n, synchronous) clears control, blit state and config; the
// frame store holds undefined data until written. No output stall.
module two_d_blitter_engine #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_command,
  input  logic [11:0] in_dest_x,
  input  logic [11:0] in_dest_y,
  input  logic [11:0] in_src_x,
  input  logic [11:0] in_src_y,
  input  logic [11:0] in_rect_width,
  input  logic [11:0] in_rect_height,
  input  logic [31:0] in_color,
  input  logic [31:0] in_key_color,
  output logic        out_valid,
  output logic [31:0] out_read_data,
  output logic        out_status,
  output logic        out_blit_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import tdb_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);

  // Command and address from the sequencer into the frame store.
  dp_cmd_t       dp_cmd;
  logic [AW-1:0] dp_rd_addr;
  logic [AW-1:0] dp_wr_addr;
  logic [31:0]   dp_color;
  logic [31:0]   dp_rdata;

  tdb_ctrl #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .AW(AW)) u_ctrl (
    .clk, .rst_n, .start, .busy,
    .in_command, .in_dest_x, .in_dest_y, .in_src_x, .in_src_y,
    .in_rect_width, .in_rect_height, .in_color, .in_key_color,
    .out_valid, .out_read_data, .out_status, .out_blit_last,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .dp_cmd, .dp_rd_addr, .dp_wr_addr, .dp_color, .dp_rdata
  );

  // Frame store: one read and one write a cycle, read data registered.
  tdb_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .AW(AW)) u_dp (
    .clk,
    .cmd     (dp_cmd),
    .rd_addr (dp_rd_addr),
    .wr_addr (dp_wr_addr),
    .color   (dp_color),
    .rdata   (dp_rdata)
  );

endmodule
